/* hw/rtl/iprt_pkg.sv */
package iprt_pkg;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_DENIED  = 3'd1;
   localparam logic [2:0] STAT_EXISTS  = 3'd2;
   localparam logic [2:0] STAT_INVALID = 3'd3;
   localparam logic [2:0] STAT_FULL    = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
   } rule_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] status;
      logic [3:0] hit_index;
   } result_type;

endpackage

/* hw/rtl/ip_port_rule_table.sv */
// Block-list of remote IPv4 address and port rules, held in a MAX_RULES deep
// memory with one read port. Each word is a lookup, an insert or a clear, and
// exactly one response word follows it. A lookup or an insert scans the stored
// rules in order at one memory read per cycle until the first hit; an insert
// that finds none then appends its rule or finds the table full. A new word is
// accepted as soon as the previous one has moved into the response register.
// The rule count bounds every read whose data is used, so the memory needs no
// clearing after reset.
module ip_port_rule_table #(
   parameter int MAX_RULES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_remote_ip,
   input  logic [15:0] req_remote_port,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_hit_index
);

   localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W = IDX_W + 1;

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   iprt_pkg::rule_type   rd_data;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   iprt_pkg::rule_type   wr_data;
   iprt_pkg::result_type result;
   logic                 out_free;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [3:0] rsp_hit_ff, rsp_hit_in;

   iprt_rule_mem #(
      .MAX_RULES (MAX_RULES),
      .IDX_W     (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   iprt_ctrl #(
      .MAX_RULES (MAX_RULES),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_remote_ip   (req_remote_ip),
      .req_remote_port (req_remote_port),
      .out_free        (out_free),
      .result          (result),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data)
   );

   // The response register may be refilled in the cycle its word is taken.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      if (result.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_hit_in    = result.hit_index;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_hit_index = rsp_hit_ff;

endmodule

/* hw/rtl/iprt_rule_mem.sv */
module iprt_rule_mem #(
   parameter int MAX_RULES = 16,
   parameter int IDX_W     = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  iprt_pkg::rule_type   wr_data,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output iprt_pkg::rule_type   rd_data
);

   iprt_pkg::rule_type mem [MAX_RULES];
   iprt_pkg::rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/iprt_ctrl.sv */
module iprt_ctrl #(
   parameter int MAX_RULES = 16,
   parameter int IDX_W     = 4,
   parameter int CNT_W     = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic [31:0]           req_remote_ip,
   input  logic [15:0]           req_remote_port,
   input  logic                  out_free,
   output iprt_pkg::result_type  result,
   output logic                  rd_en,
   output logic [IDX_W-1:0]      rd_addr,
   input  iprt_pkg::rule_type    rd_data,
   output logic                  wr_en,
   output logic [IDX_W-1:0]      wr_addr,
   output iprt_pkg::rule_type    wr_data
);

   iprt_pkg::state_type state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic [31:0]      ip_ff, ip_in;
   logic [15:0]      port_ff, port_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]       status_ff, status_in;
   logic [3:0]       hit_ff, hit_in;

   logic             hit_now;
   logic             more;
   logic [CNT_W-1:0] next_idx;
   logic             table_full;

   // A zero field in a stored rule is a wildcard; a rule of two zeros never hits.
   function automatic logic rule_hits(iprt_pkg::rule_type r, logic [31:0] ip,
                                      logic [15:0] port);
      logic a_set;
      logic p_set;
      a_set = (r.addr != 32'd0);
      p_set = (r.port != 16'd0);
      return (a_set || p_set) && (!a_set || r.addr == ip) && (!p_set || r.port == port);
   endfunction

   assign hit_now = (mode_ff == iprt_pkg::MODE_LOOKUP) ?
                    rule_hits(rd_data, ip_ff, port_ff) :
                    (rd_data.addr == ip_ff && rd_data.port == port_ff);
   assign next_idx   = CNT_W'(scan_ff) + CNT_W'(1);
   assign more       = (next_idx < count_ff);
   assign table_full = (count_ff >= CNT_W'(MAX_RULES));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iprt_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  iprt_pkg::MODE_LOOKUP: begin
                     state_in = (count_ff != '0) ? iprt_pkg::ST_SCAN : iprt_pkg::ST_DONE;
                  end
                  iprt_pkg::MODE_INSERT: begin
                     if (req_remote_ip == 32'd0 && req_remote_port == 16'd0) begin
                        state_in = iprt_pkg::ST_DONE;
                     end else if (count_ff != '0) begin
                        state_in = iprt_pkg::ST_SCAN;
                     end else begin
                        state_in = iprt_pkg::ST_APPEND;
                     end
                  end
                  default: state_in = iprt_pkg::ST_DONE;
               endcase
            end
         end
         iprt_pkg::ST_SCAN: begin
            if (hit_now) begin
               state_in = iprt_pkg::ST_DONE;
            end else if (!more) begin
               state_in = (mode_ff == iprt_pkg::MODE_INSERT) ?
                          iprt_pkg::ST_APPEND : iprt_pkg::ST_DONE;
            end
         end
         iprt_pkg::ST_APPEND: state_in = iprt_pkg::ST_DONE;
         iprt_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = iprt_pkg::ST_IDLE;
            end
         end
         default: state_in = iprt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      ip_in     = ip_ff;
      port_in   = port_ff;
      scan_in   = scan_ff;
      count_in  = count_ff;
      status_in = status_ff;
      hit_in    = hit_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = count_ff[IDX_W-1:0];
      wr_data   = '{addr: ip_ff, port: port_ff};
      req_ready = 1'b0;
      result    = '{valid: 1'b0, status: status_ff, hit_index: hit_ff};
      unique case (state_ff)
         iprt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in   = req_mode;
               ip_in     = req_remote_ip;
               port_in   = req_remote_port;
               scan_in   = '0;
               status_in = iprt_pkg::STAT_OK;
               hit_in    = 4'd0;
               rd_en     = 1'b1;
               if (req_mode == iprt_pkg::MODE_CLEAR) begin
                  count_in = '0;
               end
               if (req_mode == iprt_pkg::MODE_INSERT && req_remote_ip == 32'd0 &&
                   req_remote_port == 16'd0) begin
                  status_in = iprt_pkg::STAT_INVALID;
               end
            end
         end
         iprt_pkg::ST_SCAN: begin
            if (hit_now) begin
               status_in = (mode_ff == iprt_pkg::MODE_LOOKUP) ?
                           iprt_pkg::STAT_DENIED : iprt_pkg::STAT_EXISTS;
               hit_in    = 4'(scan_ff);
            end else if (more) begin
               scan_in = next_idx[IDX_W-1:0];
               rd_en   = 1'b1;
               rd_addr = next_idx[IDX_W-1:0];
            end
         end
         iprt_pkg::ST_APPEND: begin
            if (table_full) begin
               status_in = iprt_pkg::STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         iprt_pkg::ST_DONE: begin
            result.valid = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iprt_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      mode_ff   <= mode_in;
      ip_ff     <= ip_in;
      port_ff   <= port_in;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

endmodule
